FILE: rtl/core/lav_pkg.sv
// ----------------------------------------------------------------------------
// lav_pkg
// Shared types, widths and latencies of the look-at view matrix pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package lav_pkg;

  localparam int unsigned CompW     = 32;
  localparam int unsigned UnitW     = 18;
  localparam int unsigned VecW      = 64;
  localparam int unsigned MagW      = 62;
  localparam int unsigned LeadW     = $clog2(MagW);
  localparam int unsigned ScaledW   = 30;
  localparam int unsigned SqW       = 2 * ScaledW;
  localparam int unsigned SqrtSteps = 31;
  localparam int unsigned RadW      = 2 * SqrtSteps;
  localparam int unsigned RemW      = 35;
  localparam int unsigned DivSteps  = 17;
  localparam int unsigned NumW      = 48;
  localparam int unsigned FracW     = 16;
  localparam int unsigned ProdW     = CompW + UnitW;
  localparam int unsigned SumW      = ProdW + 2;
  localparam int unsigned XW        = SumW + 1;

  localparam int unsigned NormLat  = 5 + SqrtSteps + 1 + DivSteps + 1;
  localparam int unsigned CrossLat = 2;
  localparam int unsigned XlatLat  = 3;

  localparam int unsigned InW  = 9 * CompW;
  localparam int unsigned OutW = 264;
  localparam int unsigned PadW = OutW - 9 * UnitW - 3 * CompW;

  localparam logic signed [XW-1:0] RoundHalf = XW'(1) << (FracW - 1);
  localparam logic signed [XW-1:0] SatMax    = XW'(32'h7FFF_FFFF);
  localparam logic signed [XW-1:0] SatMin    = -SatMax - XW'(1);

  localparam logic signed [UnitW-1:0] UnitOne = UnitW'(1) << FracW;

  typedef logic signed [CompW-1:0] lav_q16_t;
  typedef logic signed [UnitW-1:0] lav_unit_t;
  typedef logic signed [VecW-1:0]  lav_vec_t;

  typedef struct packed {
    lav_q16_t  [2:0] eye;
    lav_q16_t  [2:0] upv;
    lav_unit_t [2:0] back;
    lav_unit_t [2:0] side;
  } lav_side_t;

  typedef struct packed {
    lav_q16_t  [2:0] shift;
    lav_unit_t [2:0] back;
    lav_unit_t [2:0] vert;
    lav_unit_t [2:0] side;
  } lav_res_t;

endpackage

`default_nettype wire

FILE: rtl/core/look_at_view_matrix.sv
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Right-handed look-at view matrix in fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// One request on the slave stream carries eye, target and up hint (Q16.16).
// The block returns one matrix on the master stream: rows side, vert, back
// in Q1.16 and the saturated translation column in Q16.16.
// The pipeline holds one difference stage, three normalize units of
// 55 stages each (31 square root steps and 17 divide steps, one bit a
// stage), two cross products of 2 stages and a 3-stage translation unit.
// A new request is taken every cycle unless the receiver stalls; the one
// shared pipeline enable sets this, and no unit is used twice per request.
// Zero-length vectors normalize to zero with no fault.
// Reset clears all valid bits; datapath registers are not reset.
// When the receiver stalls, the whole pipeline holds and s_axis_tready
// drops in the same cycle, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module look_at_view_matrix (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // eye_x, eye_y, eye_z, target_x, target_y, target_z,
  // upward_x, upward_y, upward_z
  input  logic [lav_pkg::InW-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // side_x, side_y, side_z, vert_x, vert_y, vert_z, back_x, back_y, back_z,
  // shift_0, shift_1, shift_2, zero fill
  output logic [lav_pkg::OutW-1:0] m_axis_tdata
);
  import lav_pkg::*;

  logic            en;
  lav_q16_t [2:0]  eye_in;
  lav_q16_t [2:0]  tgt_in;
  lav_q16_t [2:0]  upv_in;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      eye_in[i] = s_axis_tdata[CompW*i +: CompW];
      tgt_in[i] = s_axis_tdata[CompW*(3+i) +: CompW];
      upv_in[i] = s_axis_tdata[CompW*(6+i) +: CompW];
    end
  end

  // difference stage
  logic           v0_q;
  lav_vec_t [2:0] diff_q;
  lav_side_t      side0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        diff_q[i] <= VecW'(eye_in[i]) - VecW'(tgt_in[i]);
      end
      side0_q.eye  <= eye_in;
      side0_q.upv  <= upv_in;
      side0_q.back <= '0;
      side0_q.side <= '0;
    end
  end

  logic            v1, v2, v3, v4, v5;
  lav_unit_t [2:0] back_ax, side_ax, vert_ax;
  lav_vec_t  [2:0] cr1, cr2;
  lav_side_t       side1, side1b, side2, side3, side3b, side4, side5;
  lav_q16_t  [2:0] back_wide;
  lav_res_t        res;

  lav_norm u_norm_back (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v0_q), .vec_i(diff_q), .side_i(side0_q),
    .valid_o(v1), .unit_o(back_ax), .side_o(side1)
  );

  always_comb begin
    side1b      = side1;
    side1b.back = back_ax;
  end

  lav_cross u_cross_side (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v1), .a_i(side1b.upv), .b_i(back_ax),
    .side_i(side1b), .valid_o(v2), .vec_o(cr1), .side_o(side2)
  );

  lav_norm u_norm_side (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v2), .vec_i(cr1), .side_i(side2),
    .valid_o(v3), .unit_o(side_ax), .side_o(side3)
  );

  always_comb begin
    side3b      = side3;
    side3b.side = side_ax;
    for (int i = 0; i < 3; i++) back_wide[i] = CompW'(side3.back[i]);
  end

  lav_cross u_cross_vert (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v3), .a_i(back_wide), .b_i(side_ax),
    .side_i(side3b), .valid_o(v4), .vec_o(cr2), .side_o(side4)
  );

  lav_norm u_norm_vert (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v4), .vec_i(cr2), .side_i(side4),
    .valid_o(v5), .unit_o(vert_ax), .side_o(side5)
  );

  lav_xlat u_xlat (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v5),
    .side_ax_i(side5.side), .vert_ax_i(vert_ax), .back_ax_i(side5.back),
    .eye_i(side5.eye), .valid_o(m_axis_tvalid), .res_o(res)
  );

  assign m_axis_tdata = {PadW'(0), res.shift, res.back, res.vert, res.side};

  // a stalled output holds the input side
  a_stall_blocks_input: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready
  ) else $error("input accepted while output stalled");

  // a zero back axis gives an all-zero matrix
  a_zero_back: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.back == '0 |->
      res.side == '0 && res.vert == '0 && res.shift == '0
  ) else $error("nonzero matrix for zero back axis");

  // the first entry of each unit axis stays within one
  a_unit_range: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      res.back[0] <= UnitOne && res.back[0] >= -UnitOne &&
      res.side[0] <= UnitOne && res.side[0] >= -UnitOne &&
      res.vert[0] <= UnitOne && res.vert[0] >= -UnitOne
  ) else $error("rotation entry out of range");

endmodule

`default_nettype wire

FILE: rtl/core/lav_norm.sv
// ----------------------------------------------------------------------------
// lav_norm
// Pipelined 3-vector normalize: scale, square sum, bit-serial square root
// stages and bit-serial divide stages, with a sideband carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module lav_norm (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  lav_pkg::lav_vec_t  [2:0]      vec_i,
  input  lav_pkg::lav_side_t            side_i,
  output logic                          valid_o,
  output lav_pkg::lav_unit_t [2:0]      unit_o,
  output lav_pkg::lav_side_t            side_o
);
  import lav_pkg::*;

  function automatic logic [LeadW-1:0] lead_one(input logic [MagW-1:0] v);
    logic [LeadW-1:0] pos;
    pos = '0;
    for (int i = 0; i < MagW; i++) begin
      if (v[i]) pos = LeadW'(i);
    end
    return pos;
  endfunction

  // valid and sideband line
  logic [NormLat-1:0] vld_q;
  lav_side_t          side_q [NormLat];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NormLat-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int k = 1; k < NormLat; k++) side_q[k] <= side_q[k-1];
    end
  end

  // magnitude stage
  logic [2:0]      neg_a_q;
  logic [MagW-1:0] mag_a_q [3];
  logic [MagW-1:0] or_a_q;
  // leading one stage
  logic [2:0]       neg_b_q;
  logic             zero_b_q;
  logic [MagW-1:0]  mag_b_q [3];
  logic [LeadW-1:0] lead_b_q;
  // scale stage
  logic [2:0]         neg_c_q;
  logic               zero_c_q;
  logic [ScaledW-1:0] sc_c_q [3];
  // square stage
  logic [2:0]         neg_e_q;
  logic               zero_e_q;
  logic [ScaledW-1:0] sc_e_q [3];
  logic [SqW-1:0]     sq_e_q [3];

  logic [MagW-1:0] mag_a_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_a_d[i] = vec_i[i][VecW-1] ? MagW'(-vec_i[i]) : MagW'(vec_i[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        neg_a_q[i] <= vec_i[i][VecW-1];
        mag_a_q[i] <= mag_a_d[i];
        mag_b_q[i] <= mag_a_q[i];
        sc_c_q[i]  <= ScaledW'({mag_b_q[i], (ScaledW-1)'(0)} >> lead_b_q);
        sc_e_q[i]  <= sc_c_q[i];
        sq_e_q[i]  <= SqW'(sc_c_q[i]) * SqW'(sc_c_q[i]);
      end
      or_a_q   <= mag_a_d[0] | mag_a_d[1] | mag_a_d[2];
      neg_b_q  <= neg_a_q;
      zero_b_q <= (or_a_q == '0);
      lead_b_q <= lead_one(or_a_q);
      neg_c_q  <= neg_b_q;
      zero_c_q <= zero_b_q;
      neg_e_q  <= neg_c_q;
      zero_e_q <= zero_c_q;
    end
  end

  // square root stages, index 0 holds the sum of squares
  logic [RadW-1:0]      rad_q  [SqrtSteps+1];
  logic [RemW-1:0]      rem_q  [SqrtSteps+1];
  logic [SqrtSteps-1:0] root_q [SqrtSteps+1];
  logic [ScaledW-1:0]   sm_q   [SqrtSteps+1][3];
  logic [2:0]           sneg_q [SqrtSteps+1];
  logic                 szero_q[SqrtSteps+1];

  logic [RadW-1:0]      rad_d  [SqrtSteps+1];
  logic [RemW-1:0]      rem_d  [SqrtSteps+1];
  logic [SqrtSteps-1:0] root_d [SqrtSteps+1];

  always_comb begin
    logic [RemW-1:0] r2;
    logic [RemW-1:0] trial;
    rad_d[0]  = RadW'(sq_e_q[0]) + RadW'(sq_e_q[1]) + RadW'(sq_e_q[2]);
    rem_d[0]  = '0;
    root_d[0] = '0;
    for (int j = 1; j <= SqrtSteps; j++) begin
      r2       = {rem_q[j-1][RemW-3:0], rad_q[j-1][RadW-1 -: 2]};
      trial    = RemW'({root_q[j-1], 2'b01});
      rad_d[j] = rad_q[j-1] << 2;
      if (r2 >= trial) begin
        rem_d[j]  = r2 - trial;
        root_d[j] = SqrtSteps'({root_q[j-1], 1'b1});
      end else begin
        rem_d[j]  = r2;
        root_d[j] = SqrtSteps'({root_q[j-1], 1'b0});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j <= SqrtSteps; j++) begin
        rad_q[j]  <= rad_d[j];
        rem_q[j]  <= rem_d[j];
        root_q[j] <= root_d[j];
      end
      sm_q[0]    <= sc_e_q;
      sneg_q[0]  <= neg_e_q;
      szero_q[0] <= zero_e_q;
      for (int j = 1; j <= SqrtSteps; j++) begin
        sm_q[j]    <= sm_q[j-1];
        sneg_q[j]  <= sneg_q[j-1];
        szero_q[j] <= szero_q[j-1];
      end
    end
  end

  // divide stages, index 0 holds the rounded numerators
  logic [NumW-1:0]      num_q  [DivSteps+1][3];
  logic [DivSteps-1:0]  quo_q  [DivSteps+1][3];
  logic [SqrtSteps-1:0] len_q  [DivSteps+1];
  logic [2:0]           dneg_q [DivSteps+1];
  logic                 dzero_q[DivSteps+1];

  logic [NumW-1:0]      num_d  [DivSteps+1][3];
  logic [DivSteps-1:0]  quo_d  [DivSteps+1][3];

  always_comb begin
    logic [SqrtSteps-1:0] len0;
    logic [NumW-1:0]      cmp;
    len0 = root_q[SqrtSteps];
    for (int i = 0; i < 3; i++) begin
      num_d[0][i] = NumW'({sm_q[SqrtSteps][i], FracW'(0)}) + NumW'(len0 >> 1);
      quo_d[0][i] = '0;
    end
    for (int k = 1; k <= DivSteps; k++) begin
      cmp = NumW'(len_q[k-1]) << (DivSteps - k);
      for (int i = 0; i < 3; i++) begin
        if (num_q[k-1][i] >= cmp) begin
          num_d[k][i] = num_q[k-1][i] - cmp;
          quo_d[k][i] = DivSteps'({quo_q[k-1][i], 1'b1});
        end else begin
          num_d[k][i] = num_q[k-1][i];
          quo_d[k][i] = DivSteps'({quo_q[k-1][i], 1'b0});
        end
      end
    end
  end

  lav_unit_t [2:0] unit_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k <= DivSteps; k++) begin
        num_q[k] <= num_d[k];
        quo_q[k] <= quo_d[k];
      end
      len_q[0]   <= root_q[SqrtSteps];
      dneg_q[0]  <= sneg_q[SqrtSteps];
      dzero_q[0] <= szero_q[SqrtSteps];
      for (int k = 1; k <= DivSteps; k++) begin
        len_q[k]   <= len_q[k-1];
        dneg_q[k]  <= dneg_q[k-1];
        dzero_q[k] <= dzero_q[k-1];
      end
      for (int i = 0; i < 3; i++) begin
        if (dzero_q[DivSteps]) begin
          unit_q[i] <= '0;
        end else if (dneg_q[DivSteps][i]) begin
          unit_q[i] <= -UnitW'(quo_q[DivSteps][i]);
        end else begin
          unit_q[i] <= UnitW'(quo_q[DivSteps][i]);
        end
      end
    end
  end

  assign valid_o = vld_q[NormLat-1];
  assign side_o  = side_q[NormLat-1];
  assign unit_o  = unit_q;

endmodule

`default_nettype wire

FILE: rtl/core/lav_cross.sv
// ----------------------------------------------------------------------------
// lav_cross
// Two-stage cross product: registered partial products, then differences.
// ----------------------------------------------------------------------------
`default_nettype none

module lav_cross (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  lav_pkg::lav_q16_t  [2:0] a_i,
  input  lav_pkg::lav_unit_t [2:0] b_i,
  input  lav_pkg::lav_side_t       side_i,
  output logic                     valid_o,
  output lav_pkg::lav_vec_t  [2:0] vec_o,
  output lav_pkg::lav_side_t       side_o
);
  import lav_pkg::*;

  logic [CrossLat-1:0]     vld_q;
  lav_side_t               side_q [CrossLat];
  logic signed [ProdW-1:0] prod_q [6];
  lav_vec_t [2:0]          vec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[CrossLat-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      side_q[1] <= side_q[0];
      prod_q[0] <= ProdW'(a_i[1]) * ProdW'(b_i[2]);
      prod_q[1] <= ProdW'(a_i[2]) * ProdW'(b_i[1]);
      prod_q[2] <= ProdW'(a_i[2]) * ProdW'(b_i[0]);
      prod_q[3] <= ProdW'(a_i[0]) * ProdW'(b_i[2]);
      prod_q[4] <= ProdW'(a_i[0]) * ProdW'(b_i[1]);
      prod_q[5] <= ProdW'(a_i[1]) * ProdW'(b_i[0]);
      vec_q[0]  <= VecW'(prod_q[0]) - VecW'(prod_q[1]);
      vec_q[1]  <= VecW'(prod_q[2]) - VecW'(prod_q[3]);
      vec_q[2]  <= VecW'(prod_q[4]) - VecW'(prod_q[5]);
    end
  end

  assign valid_o = vld_q[CrossLat-1];
  assign side_o  = side_q[CrossLat-1];
  assign vec_o   = vec_q;

endmodule

`default_nettype wire

FILE: rtl/core/lav_xlat.sv
// ----------------------------------------------------------------------------
// lav_xlat
// Translation column: axis dot eye, negate, round half up and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module lav_xlat (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  lav_pkg::lav_unit_t [2:0] side_ax_i,
  input  lav_pkg::lav_unit_t [2:0] vert_ax_i,
  input  lav_pkg::lav_unit_t [2:0] back_ax_i,
  input  lav_pkg::lav_q16_t  [2:0] eye_i,
  output logic                     valid_o,
  output lav_pkg::lav_res_t        res_o
);
  import lav_pkg::*;

  logic [XlatLat-1:0]      vld_q;
  lav_res_t                rot_q [XlatLat-1];
  logic signed [ProdW-1:0] prod_q [3][3];
  logic signed [SumW-1:0]  sum_q [3];
  lav_res_t                res_q;
  lav_unit_t [2:0]         ax [3];
  logic signed [XW-1:0]    rnd [3];
  logic signed [XW-1:0]    flr [3];

  assign ax[0] = side_ax_i;
  assign ax[1] = vert_ax_i;
  assign ax[2] = back_ax_i;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      rnd[r] = -XW'(sum_q[r]) + RoundHalf;
      flr[r] = rnd[r] >>> FracW;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[XlatLat-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rot_q[0].side  <= side_ax_i;
      rot_q[0].vert  <= vert_ax_i;
      rot_q[0].back  <= back_ax_i;
      rot_q[0].shift <= '0;
      rot_q[1]       <= rot_q[0];
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= ProdW'(ax[r][c]) * ProdW'(eye_i[c]);
        end
        sum_q[r] <= SumW'(prod_q[r][0]) + SumW'(prod_q[r][1]) + SumW'(prod_q[r][2]);
      end
      res_q.side <= rot_q[1].side;
      res_q.vert <= rot_q[1].vert;
      res_q.back <= rot_q[1].back;
      for (int r = 0; r < 3; r++) begin
        if (flr[r] > SatMax) begin
          res_q.shift[r] <= CompW'(SatMax);
        end else if (flr[r] < SatMin) begin
          res_q.shift[r] <= CompW'(SatMin);
        end else begin
          res_q.shift[r] <= CompW'(flr[r]);
        end
      end
    end
  end

  assign valid_o = vld_q[XlatLat-1];
  assign res_o   = res_q;

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the fixed-point look-at view matrix pipeline.
// ----------------------------------------------------------------------------
// Camera requests are sent on the slave stream with random gaps. Each
// accepted request is run through a local fixed-point model of the
// normalize, cross and translation math. The predicted matrix is queued.
// Every matrix taken from the master stream is compared field by field
// with the oldest prediction. The receiver stalls at random, and once
// holds off long enough to back the whole pipeline up.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import lav_pkg::*;

  typedef longint vec3_t [3];

  localparam int NumFields = 12;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  // eye_x, eye_y, eye_z, target_x, target_y, target_z,
  // upward_x, upward_y, upward_z
  logic [InW-1:0]     s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  // side_x..z, vert_x..z, back_x..z, shift_0..2, zero fill
  logic [OutW-1:0]    m_axis_tdata;

  logic [OutW-1:0] matrix_q[$];
  int unsigned     error_count = 0;
  int unsigned     sent_count = 0;
  int unsigned     matrix_count = 0;
  bit              calm = 1'b0;
  int unsigned     hold_cycles = 0;

  look_at_view_matrix dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic vec3_t unit_vec(vec3_t v);
    longint unsigned mag[3];
    bit              neg[3];
    longint unsigned mx = 0;
    longint unsigned sq, len, q;
    vec3_t           r;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i] < 0;
      mag[i] = neg[i] ? longint'(-v[i]) : longint'(v[i]);
      if (mag[i] > mx) mx = mag[i];
    end
    if (mx == 0) begin
      r = '{0, 0, 0};
      return r;
    end
    while (mx >= (64'd1 << 30)) begin
      mx = mx >> 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx = mx << 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
    end
    sq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    len = int_sqrt(sq);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << 16) + (len >> 1)) / len;
      r[i] = neg[i] ? -longint'(q) : longint'(q);
    end
    return r;
  endfunction

  function automatic vec3_t cross_prod(vec3_t a, vec3_t b);
    vec3_t r;
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
    return r;
  endfunction

  function automatic logic [31:0] shift_of(vec3_t axis, vec3_t eye);
    longint s = axis[0] * eye[0] + axis[1] * eye[1] + axis[2] * eye[2];
    longint t = (-s + 32768) >>> 16;
    if (t > 64'sd2147483647) t = 64'sd2147483647;
    if (t < -64'sd2147483648) t = -64'sd2147483648;
    return t[31:0];
  endfunction

  function automatic logic [OutW-1:0] view_matrix(logic [InW-1:0] req);
    vec3_t eye, tgt, upv, d, side, vert, back;
    logic [OutW-1:0] m = '0;
    for (int i = 0; i < 3; i++) begin
      eye[i] = longint'($signed(req[32*i +: 32]));
      tgt[i] = longint'($signed(req[32*(3+i) +: 32]));
      upv[i] = longint'($signed(req[32*(6+i) +: 32]));
      d[i] = eye[i] - tgt[i];
    end
    back = unit_vec(d);
    side = unit_vec(cross_prod(upv, back));
    vert = unit_vec(cross_prod(back, side));
    for (int i = 0; i < 3; i++) begin
      m[18*i +: 18]     = side[i][17:0];
      m[18*(3+i) +: 18] = vert[i][17:0];
      m[18*(6+i) +: 18] = back[i][17:0];
    end
    m[162 +: 32] = shift_of(side, eye);
    m[194 +: 32] = shift_of(vert, eye);
    m[226 +: 32] = shift_of(back, eye);
    return m;
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    error_count++;
    $display("mismatch on matrix %0d, %s: got %h, expected %h",
             matrix_count, field, got, want);
  endtask

  // result checker
  always @(posedge clk_i) begin
    logic [OutW-1:0] want;
    string names[NumFields];
    names = '{"side_x", "side_y", "side_z", "vert_x", "vert_y", "vert_z",
              "back_x", "back_y", "back_z", "shift_0", "shift_1", "shift_2"};
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (matrix_q.size() == 0) begin
        error_count++;
        $display("unexpected matrix %h", m_axis_tdata);
      end else begin
        want = matrix_q.pop_front();
        for (int i = 0; i < 9; i++)
          if (m_axis_tdata[18*i +: 18] !== want[18*i +: 18])
            report(names[i], 32'(m_axis_tdata[18*i +: 18]), 32'(want[18*i +: 18]));
        for (int i = 0; i < 3; i++)
          if (m_axis_tdata[162+32*i +: 32] !== want[162+32*i +: 32])
            report(names[9+i], m_axis_tdata[162+32*i +: 32], want[162+32*i +: 32]);
      end
      matrix_count++;
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (hold_cycles != 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 32);
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send(logic [31:0] ex, ey, ez, tx, ty, tz, ux, uy, uz);
    logic [InW-1:0] req = {uz, uy, ux, tz, ty, tx, ez, ey, ex};
    while (!calm && $urandom_range(99) < 32) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = req;
    do @(posedge clk_i); while (!s_axis_tready);
    matrix_q.push_back(view_matrix(req));
    sent_count++;
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_q16(int kind);
    case (kind)
      0: return $urandom;
      1: return 32'($signed($urandom_range(2097152)) - 1048576);
      default: return 32'($signed($urandom_range(16)) - 8);
    endcase
  endfunction

  task automatic send_random(int kind);
    logic [31:0] e[3], t[3], u[3];
    for (int i = 0; i < 3; i++) begin
      e[i] = rand_q16(kind);
      t[i] = rand_q16(kind);
      u[i] = rand_q16(kind);
    end
    case ($urandom_range(15))
      0: t = e;                                   // degenerate back axis
      1: u = '{32'h0, 32'h0, 32'h0};              // missing up hint
      2: for (int i = 0; i < 3; i++) u[i] = e[i] - t[i];
      default: ;
    endcase
    send(e[0], e[1], e[2], t[0], t[1], t[2], u[0], u[1], u[2]);
  endtask

  task automatic test_directed();
    send(32'h0, 32'h0, 32'h0005_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0);
    send(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
         32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
         32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    send(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
         32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
         32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    // eye on target
    send(32'h1234_5678, 32'hFEDC_BA98, 32'h0, 32'h1234_5678, 32'hFEDC_BA98, 32'h0,
         32'h0, 32'h0001_0000, 32'h0);
    // up hint zero, then parallel to the view line
    send(32'h0003_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send(32'h0003_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'hFFF0_0000, 32'h0, 32'h0);
    // translation saturation
    send(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0,
         32'h0, 32'h0001_0000, 32'h0);
    send(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
         32'h8000_0000, 32'h0, 32'h0, 32'h0001_0000);
    send(32'h0000_0001, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1);
    send(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0);
    send(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
         32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
         32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_random($urandom_range(2));
  endtask

  task automatic test_back_to_back(int n);
    calm = 1'b1;
    for (int i = 0; i < n; i++) send_random($urandom_range(2));
    calm = 1'b0;
  endtask

  task automatic test_backpressure(int n);
    hold_cycles = 400;
    for (int i = 0; i < n; i++) send_random($urandom_range(2));
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(400);
    test_back_to_back(250);
    test_backpressure(300);
    test_random(150);
    s_axis_tvalid = 1'b0;
    while (matrix_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("sent %0d camera requests, checked %0d matrices", sent_count, matrix_count);
    $display("covered degenerate axes, saturation, gaps, stalls and a full backup");
    if (error_count == 0 && matrix_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d matrices outstanding", matrix_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
